// ----- hdl/assert_macros.svh -----
// assertion macros used by the pid controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/pid_aw_pkg.sv -----
// package: register indexes, opcodes, reset values and widths of the pid controller
`timescale 1ns / 1ps

package pid_aw_pkg;

    localparam int ErrW   = 16;
    localparam int GainW  = 16;
    localparam int LimW   = 15;
    localparam int DriveW = 32;
    localparam int CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_P    = 2'd0,
        CFG_GAIN_I    = 2'd1,
        CFG_GAIN_D    = 2'd2,
        CFG_INT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } t_opcode;

    localparam logic signed [GainW-1:0] GainPReset   = 16'sd256;
    localparam logic signed [GainW-1:0] GainIReset   = 16'sd0;
    localparam logic signed [GainW-1:0] GainDReset   = 16'sd0;
    localparam logic [LimW-1:0]         IntLimitReset = 15'd15360;

endpackage

// ----- hdl/pid_antiwindup_controller.sv -----
// pid controller with integral clamp: top level
`timescale 1ns / 1ps
//
// usage
// input channel: i_valid, i_opcode, i_error_in; the block answers with o_stall.
//   an item is taken at a rising edge with i_valid high and o_stall low.
//   a compute item yields one result; a clear item zeroes the integral and the
//   previous error and yields nothing.
// output channel: o_valid, o_drive_out; the receiver answers with i_stall.
// config channel: i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready (always high).
//   write gains and limit only while no item is in flight.
// path: a compute item is taken into the input register; multiplies, sum and rounding
//   feed the result register, which drives o_drive_out.
// throughput: one item per cycle while o_stall is low; the integral and previous
//   error update in the accept cycle, so the next item may follow at once.
// reset: synchronous, active low; empties both registers, clears the integral, the
//   previous error and loads the default gains and limit.
// stall: a held output keeps its value; the input register fills, then o_stall rises.
//
`include "assert_macros.svh"

module pid_antiwindup_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_opcode,
    input  logic signed [pid_aw_pkg::ErrW-1:0]    i_error_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pid_aw_pkg::DriveW-1:0]  o_drive_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pid_aw_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [pid_aw_pkg::GainW-1:0]          i_cfg_data
);

    localparam int ErrW  = pid_aw_pkg::ErrW;
    localparam int GainW = pid_aw_pkg::GainW;
    localparam int LimW  = pid_aw_pkg::LimW;
    localparam int DriveW = pid_aw_pkg::DriveW;
    localparam int AccW  = ErrW + 1;
    localparam int ProdW = GainW + ErrW;
    localparam int ProdDW = GainW + AccW;
    localparam int SumW  = ProdDW + 3;
    localparam int RndSh = 10;

    // configuration
    logic signed [GainW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LimW-1:0]         r_int_limit;

    // controller memory
    logic signed [ErrW-1:0] r_integral, n_integral;
    logic signed [ErrW-1:0] r_last_error, n_last_error;

    // input and result registers
    logic                     r_v1, r_out_valid;
    logic signed [ErrW-1:0]   r_e1, r_acc1;
    logic signed [AccW-1:0]   r_diff1;
    logic signed [DriveW-1:0] r_drive;

    logic rdy1, rdy2;
    logic in_acc, in_compute, in_clear;

    logic signed [AccW-1:0]   n_acc_raw, lim_pos, lim_neg, n_diff;
    logic signed [ErrW-1:0]   n_acc;
    logic signed [ProdW-1:0]  n_prod_p, n_prod_i;
    logic signed [ProdDW-1:0] n_prod_d;
    logic signed [SumW-1:0]   p_ext, i_ext, d_ext, n_sum;
    logic signed [DriveW-1:0] n_drive;

    assign rdy2 = !r_out_valid || !i_stall;
    assign rdy1 = !r_v1 || rdy2;

    assign o_stall     = !rdy1;
    assign o_valid     = r_out_valid;
    assign o_drive_out = r_drive;
    assign o_cfg_ready = 1'b1;

    assign in_acc     = i_valid && rdy1;
    assign in_compute = in_acc && (i_opcode == pid_aw_pkg::OP_COMPUTE);
    assign in_clear   = in_acc && (i_opcode == pid_aw_pkg::OP_CLEAR);

    // integral update with clamp, and difference against previous error
    always_comb begin
        n_acc_raw = AccW'(r_integral) + AccW'(i_error_in);
        lim_pos   = AccW'({1'b0, r_int_limit});
        lim_neg   = -lim_pos;
        if (n_acc_raw > lim_pos) begin
            n_acc = ErrW'(lim_pos);
        end else if (n_acc_raw < lim_neg) begin
            n_acc = ErrW'(lim_neg);
        end else begin
            n_acc = ErrW'(n_acc_raw);
        end
        n_diff = AccW'(i_error_in) - AccW'(r_last_error);

        n_integral   = r_integral;
        n_last_error = r_last_error;
        if (in_clear) begin
            n_integral   = '0;
            n_last_error = '0;
        end else if (in_compute) begin
            n_integral   = n_acc;
            n_last_error = i_error_in;
        end
    end

    assign n_prod_p = r_gain_p * r_e1;
    assign n_prod_i = r_gain_i * r_acc1;
    assign n_prod_d = ProdDW'(r_gain_d) * ProdDW'(r_diff1);

    // align to 18 fraction bits, round to 8 with ties toward plus infinity
    always_comb begin
        p_ext   = SumW'(n_prod_p) <<< 2;
        i_ext   = SumW'(n_prod_i);
        d_ext   = SumW'(n_prod_d) <<< 2;
        n_sum   = p_ext + i_ext + d_ext + (SumW'(1) <<< (RndSh - 1));
        n_drive = DriveW'(n_sum >>> RndSh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= pid_aw_pkg::GainPReset;
            r_gain_i     <= pid_aw_pkg::GainIReset;
            r_gain_d     <= pid_aw_pkg::GainDReset;
            r_int_limit  <= pid_aw_pkg::IntLimitReset;
            r_integral   <= '0;
            r_last_error <= '0;
            r_v1         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (pid_aw_pkg::t_cfg_idx'(i_cfg_index))
                    pid_aw_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                    pid_aw_pkg::CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                    pid_aw_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                    pid_aw_pkg::CFG_INT_LIMIT: r_int_limit <= i_cfg_data[LimW-1:0];
                    default: ;
                endcase
            end
            r_integral   <= n_integral;
            r_last_error <= n_last_error;
            if (rdy1) begin
                r_v1 <= in_compute;
            end
            if (rdy2) begin
                r_out_valid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && in_compute) begin
            r_e1    <= i_error_in;
            r_acc1  <= n_acc;
            r_diff1 <= n_diff;
        end
        if (rdy2 && r_v1) begin
            r_drive <= n_drive;
        end
    end

    `ASSERT_NEXT(a_int_in_limit, i_clk, i_rst_n, in_compute,
        (r_integral <= $signed({2'b00, $past(r_int_limit)})) &&
        (r_integral >= -$signed({2'b00, $past(r_int_limit)})))
    `ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, in_clear,
        (r_integral == '0) && (r_last_error == '0))
    `ASSERT_NEXT(a_clear_no_item, i_clk, i_rst_n, in_clear, !r_v1)

endmodule

// ----- sim/tb_pid_antiwindup_controller.sv -----
`timescale 1ns / 1ps
// testbench for the pid controller with integral clamp: directed and random items checked against a predictor
module tb_pid_antiwindup_controller;
    import pid_aw_pkg::*;

    localparam int HoldCycles  = 80;
    localparam int StuckLimit  = 2000;
    localparam int DrainCycles = 8;
    localparam int RandPhases  = 5;
    localparam int PhaseItems  = 140;

    typedef struct packed {
        t_opcode                op;
        logic signed [ErrW-1:0] err;
    } t_ctrl_item;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     i_opcode    = OP_COMPUTE;
    logic signed [ErrW-1:0]   i_error_in  = '0;
    logic                     i_stall     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_index = '0;
    logic [GainW-1:0]         i_cfg_data  = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DriveW-1:0] o_drive_out;
    logic                     o_cfg_ready;

    t_ctrl_item               pending_items[$];
    logic signed [DriveW-1:0] expected_drive[$];
    int                       fail_count   = 0;
    int                       items_pushed = 0;
    int                       items_taken  = 0;
    bit                       gaps_on      = 1'b1;
    int                       tx_gap       = 0;
    int                       rx_wait      = 0;
    int                       rx_hold      = 0;
    int                       rx_count     = 0;

    // controller copy: gains, limit, integral and previous error
    logic signed [GainW-1:0]  kp       = GainPReset;
    logic signed [GainW-1:0]  ki       = GainIReset;
    logic signed [GainW-1:0]  kd       = GainDReset;
    logic [LimW-1:0]          int_lim  = IntLimitReset;
    logic signed [ErrW-1:0]   int_acc  = '0;
    logic signed [ErrW-1:0]   prev_err = '0;

    pid_antiwindup_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_error_in  (i_error_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive_out (o_drive_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [DriveW-1:0] pid_drive(input logic signed [ErrW-1:0] err);
        longint e;
        longint lim;
        longint acc;
        longint diff;
        longint total;
        longint q;
        e     = err;
        lim   = int_lim;
        acc   = longint'(int_acc) + e;
        if (acc > lim) begin
            acc = lim;
        end
        if (acc < -lim) begin
            acc = -lim;
        end
        diff  = e - longint'(prev_err);
        total = longint'(kp) * e * 4 + longint'(ki) * acc + longint'(kd) * diff * 4;
        // round to q24.8, ties toward plus infinity
        q     = (total + 512) >>> 10;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
        end
        int_acc  = acc[ErrW-1:0];
        prev_err = err;
        return q[DriveW-1:0];
    endfunction

    always @(posedge i_clk) begin : driver
        t_ctrl_item next_item;
        bit         offering;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  = 0;
        end else begin
            offering = i_valid;
            if (i_valid && !o_stall) begin
                offering = 1'b0;
                tx_gap   = gaps_on ? $urandom_range(0, 10) : 0;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() > 0) begin
                    next_item  = pending_items.pop_front();
                    i_opcode   <= next_item.op;
                    i_error_in <= next_item.err;
                    offering   = 1'b1;
                end
            end
            i_valid <= offering;
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            rx_wait  = 0;
            rx_hold  = 0;
            rx_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_count++;
                rx_wait = gaps_on ? $urandom_range(0, 10) : 0;
                // long hold-off so the pipeline backs up into the input
                if (rx_count % 200 == 60) begin
                    rx_hold = HoldCycles;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic signed [DriveW-1:0] want;
        if (!i_rst_n) begin
            kp       = GainPReset;
            ki       = GainIReset;
            kd       = GainDReset;
            int_lim  = IntLimitReset;
            int_acc  = '0;
            prev_err = '0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_drive.size() == 0) begin
                    $error("drive_out: expected none, actual %0d", o_drive_out);
                    fail_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (o_drive_out !== want) begin
                        $error("drive_out: expected %0d, actual %0d", want, o_drive_out);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:    kp = i_cfg_data;
                    CFG_GAIN_I:    ki = i_cfg_data;
                    CFG_GAIN_D:    kd = i_cfg_data;
                    CFG_INT_LIMIT: int_lim = i_cfg_data[LimW-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                items_taken++;
                if (i_opcode == OP_CLEAR) begin
                    int_acc  = '0;
                    prev_err = '0;
                end else begin
                    expected_drive.push_back(pid_drive(i_error_in));
                end
            end
        end
    end

    task automatic push_item(input t_opcode op, input logic [ErrW-1:0] err);
        t_ctrl_item it;
        it.op  = op;
        it.err = err;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [GainW-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (items_taken != items_pushed || expected_drive.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [GainW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [GainW-1:0] pick_limit();
        logic [LimW-1:0] lim;
        case ($urandom_range(0, 4))
            0: lim = 15'h7FFF;
            1: lim = 15'h0000;
            2: lim = 15'($urandom_range(1, 2000));
            default: lim = 15'($urandom());
        endcase
        return {1'($urandom_range(0, 1)), lim};
    endfunction

    function automatic logic [ErrW-1:0] pick_error();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: error extremes, clear, first step after clear
        push_item(OP_COMPUTE, 16'h0000);
        push_item(OP_COMPUTE, 16'h7FFF);
        push_item(OP_COMPUTE, 16'h8000);
        push_item(OP_COMPUTE, 16'h0001);
        push_item(OP_COMPUTE, 16'hFFFF);
        push_item(OP_CLEAR,   16'h7FFF);
        push_item(OP_COMPUTE, 16'h8000);
        wait_idle();

        // most negative gains, widest limit, full swing of the derivative
        write_reg(CFG_GAIN_P, 16'h8000);
        write_reg(CFG_GAIN_I, 16'h8000);
        write_reg(CFG_GAIN_D, 16'h8000);
        write_reg(CFG_INT_LIMIT, 16'hFFFF);
        push_item(OP_COMPUTE, 16'h7FFF);
        push_item(OP_COMPUTE, 16'h8000);
        push_item(OP_COMPUTE, 16'h7FFF);
        push_item(OP_COMPUTE, 16'h8000);
        push_item(OP_COMPUTE, 16'h7FFF);
        push_item(OP_CLEAR,   16'h5555);
        wait_idle();

        // zero limit holds the integral at zero
        write_reg(CFG_GAIN_P, 16'h7FFF);
        write_reg(CFG_GAIN_I, 16'h7FFF);
        write_reg(CFG_GAIN_D, 16'h7FFF);
        write_reg(CFG_INT_LIMIT, 16'h0000);
        push_item(OP_COMPUTE, 16'd1000);
        push_item(OP_COMPUTE, -16'sd1000);
        push_item(OP_COMPUTE, 16'h7FFF);
        wait_idle();

        // integral built up, then the limit lowered under it
        write_reg(CFG_INT_LIMIT, 16'h7FFF);
        push_item(OP_COMPUTE, 16'd16000);
        push_item(OP_COMPUTE, 16'd16000);
        wait_idle();
        write_reg(CFG_INT_LIMIT, 16'd100);
        push_item(OP_COMPUTE, 16'h0000);
        push_item(OP_COMPUTE, -16'sd300);
        wait_idle();

        for (int ph = 0; ph < RandPhases; ph++) begin
            gaps_on = (ph != 2);
            write_reg(CFG_GAIN_P, pick_gain());
            write_reg(CFG_GAIN_I, pick_gain());
            write_reg(CFG_GAIN_D, pick_gain());
            write_reg(CFG_INT_LIMIT, pick_limit());
            for (int n = 0; n < PhaseItems; n++) begin
                if ($urandom_range(0, 99) < 8) begin
                    push_item(OP_CLEAR, 16'($urandom()));
                end else begin
                    push_item(OP_COMPUTE, pick_error());
                end
            end
            wait_idle();
        end

        if (expected_drive.size() != 0) begin
            $error("drive_out: %0d results never arrived", expected_drive.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_pid_antiwindup_controller: PASS");
        end else begin
            $display("tb_pid_antiwindup_controller: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < StuckLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("tb_pid_antiwindup_controller: FAIL");
        $finish;
    end

endmodule
